/* src/gtr_pkg.sv */
// graph traversal package: field widths, mode codes and default sizes
// no dependencies; imported by the top level
`default_nettype none

package gtr_pkg;

  localparam int NODES_DEF = 16;
  localparam int NODE_W    = 5;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BFS    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DFS    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

endpackage : gtr_pkg

`default_nettype wire

/* src/gtr_prienc.sv */
// shared neighbor finder: priority encoder over the candidate vector
// picks the lowest set bit, or the highest one when rev is set; no dependencies
`default_nettype none

module gtr_prienc #(
  parameter int NODES = 16,
  parameter int IW    = $clog2(NODES)
) (
  input  wire logic [NODES-1:0] vec,
  input  wire logic             rev,
  output logic                  found,
  output logic [IW-1:0]         idx
);

  logic [NODES-1:0] scan_v;
  logic [IW-1:0]    low_idx;

  // reverse the vector so that one lowest-bit search serves both directions
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      scan_v[i] = rev ? vec[NODES-1-i] : vec[i];
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (scan_v[i]) begin
        low_idx = IW'(i);
      end
    end
  end

  assign found = |vec;
  assign idx   = rev ? (IW'(NODES - 1) - low_idx) : low_idx;

endmodule : gtr_prienc

`default_nettype wire

/* src/graph_traversal_bfs_dfs.sv */
// Graph traversal block: breadth-first / depth-first search over an undirected
// adjacency matrix on nodes 1..NODES. Input channel (in_*) takes one command per
// transaction: mode 0 adds edge in_edge_from - in_edge_to (ignored if an endpoint
// is 0 or above NODES), mode 1 runs BFS and mode 2 runs DFS from in_start_node.
// Traversals give one out_node transaction per visited node in visiting order,
// with out_last set on the final one; a bad start node or mode 3 gives nothing.
// An edge add is a read-modify-write of both rows in the adjacency memory. A
// traversal pops a node, reads its row, loads the unvisited neighbors and scans
// them (the shared priority encoder finds one unvisited neighbor per cycle),
// then finishes once the queue or stack is empty. in_stall is high for the
// whole run.
// Each result leaves one step behind its node, since last is known only once the
// queue or stack has drained. A stalled output holds its transaction and the
// sequencer waits when the next result is ready; the output register lets a
// new command enter while the final result still waits.
// Reset (rst_n, synchronous) clears all edges through per-row valid bits, the
// sequencer and the output, with no clearing pass.
// Depends on gtr_pkg and gtr_prienc.
`default_nettype none

module graph_traversal_bfs_dfs
  import gtr_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [NODE_W-1:0] in_edge_from,
  input  wire logic [NODE_W-1:0] in_edge_to,
  input  wire logic [NODE_W-1:0] in_start_node,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NODE_W-1:0]      out_node,
  output logic                   out_last
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int XW = ((CW > NODE_W) ? CW : NODE_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_E_WRA, S_E_WRB, S_POP, S_ROW, S_LD, S_SCAN, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    tail_r, tail_nxt;
  logic [NODES-1:0] visited_r, visited_nxt;
  logic             dfs_r, dfs_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [NODES-1:0] row_vld_r;

  // payload registers
  logic [IW-1:0]     a_r, a_nxt;
  logic [IW-1:0]     b_r, b_nxt;
  logic [IW-1:0]     hold_r, hold_nxt;
  logic [NODES-1:0]  cand_r, cand_nxt;
  logic [NODE_W-1:0] out_node_r, out_node_nxt;
  logic              out_last_r, out_last_nxt;

  // adjacency memory
  logic [NODES-1:0] adj_mem [NODES];
  logic             adj_we, adj_re;
  logic [IW-1:0]    adj_wa, adj_ra;
  logic [NODES-1:0] adj_wd;
  logic [NODES-1:0] adj_rd_r;
  logic             adj_rd_vld_r;
  logic [NODES-1:0] adj_row;

  // pending queue / stack memory
  logic [IW-1:0] st_mem [NODES];
  logic          st_we, st_re;
  logic [IW-1:0] st_wa, st_ra, st_wd;
  logic [IW-1:0] st_rd_r;

  logic             in_acc, out_free;
  logic [XW-1:0]    from_x, to_x, start_x, out_x;
  logic             from_ok, to_ok, start_ok;
  logic [IW-1:0]    from_i, to_i, start_i;
  logic             pe_found;
  logic [IW-1:0]    pe_idx;
  logic [NODES-1:0] pe_bit;
  logic             empty;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign from_x   = XW'(in_edge_from);
  assign to_x     = XW'(in_edge_to);
  assign start_x  = XW'(in_start_node);
  assign from_ok  = (from_x != '0) && (from_x <= XW'(NODES));
  assign to_ok    = (to_x != '0) && (to_x <= XW'(NODES));
  assign start_ok = (start_x != '0) && (start_x <= XW'(NODES));
  assign from_i   = IW'(from_x - XW'(1));
  assign to_i     = IW'(to_x - XW'(1));
  assign start_i  = IW'(start_x - XW'(1));

  assign adj_row = adj_rd_vld_r ? adj_rd_r : '0;
  assign empty   = dfs_r ? (tail_r == '0) : (head_r == tail_r);
  assign pe_bit  = {{(NODES-1){1'b0}}, 1'b1} << pe_idx;
  assign out_x   = XW'(hold_r) + XW'(1);

  gtr_prienc #(
    .NODES (NODES),
    .IW    (IW)
  ) u_prienc (
    .vec   (cand_r),
    .rev   (dfs_r),
    .found (pe_found),
    .idx   (pe_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    visited_nxt   = visited_r;
    dfs_nxt       = dfs_r;
    hold_v_nxt    = hold_v_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    hold_nxt      = hold_r;
    cand_nxt      = cand_r;
    out_node_nxt  = out_node_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    adj_we        = 1'b0;
    adj_wa        = a_r;
    adj_wd        = adj_row | ({{(NODES-1){1'b0}}, 1'b1} << b_r);
    adj_re        = 1'b0;
    adj_ra        = from_i;
    st_we         = 1'b0;
    st_wa         = tail_r[IW-1:0];
    st_wd         = pe_idx;
    st_re         = 1'b0;
    st_ra         = head_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_ADD) begin
            if (from_ok && to_ok) begin
              adj_re    = 1'b1;
              adj_ra    = from_i;
              a_nxt     = from_i;
              b_nxt     = to_i;
              state_nxt = S_E_WRA;
            end
          end else if ((in_mode == MODE_BFS || in_mode == MODE_DFS) && start_ok) begin
            st_we       = 1'b1;
            st_wa       = '0;
            st_wd       = start_i;
            visited_nxt = {{(NODES-1){1'b0}}, 1'b1} << start_i;
            head_nxt    = '0;
            tail_nxt    = CW'(1);
            dfs_nxt     = (in_mode == MODE_DFS);
            hold_v_nxt  = 1'b0;
            state_nxt   = S_POP;
          end
        end
      end
      S_E_WRA: begin
        // row a gets bit b, then row b is read for its own update
        adj_we    = 1'b1;
        adj_wa    = a_r;
        adj_wd    = adj_row | ({{(NODES-1){1'b0}}, 1'b1} << b_r);
        adj_re    = 1'b1;
        adj_ra    = b_r;
        state_nxt = S_E_WRB;
      end
      S_E_WRB: begin
        adj_we    = 1'b1;
        adj_wa    = b_r;
        adj_wd    = adj_row | ({{(NODES-1){1'b0}}, 1'b1} << a_r);
        state_nxt = S_IDLE;
      end
      S_POP: begin
        if (empty) begin
          state_nxt = S_DONE;
        end else begin
          st_re = 1'b1;
          if (dfs_r) begin
            st_ra    = IW'(tail_r - CW'(1));
            tail_nxt = tail_r - CW'(1);
          end else begin
            st_ra    = head_r[IW-1:0];
            head_nxt = head_r + CW'(1);
          end
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        // previous node goes out as not-last once the output register is free
        if (!hold_v_r || out_free) begin
          if (hold_v_r) begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = out_x[NODE_W-1:0];
            out_last_nxt  = 1'b0;
          end
          hold_nxt   = st_rd_r;
          hold_v_nxt = 1'b1;
          adj_re     = 1'b1;
          adj_ra     = st_rd_r;
          state_nxt  = S_LD;
        end
      end
      S_LD: begin
        cand_nxt  = adj_row & ~visited_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pe_found) begin
          if (tail_r < CW'(NODES)) begin
            st_we       = 1'b1;
            st_wa       = tail_r[IW-1:0];
            st_wd       = pe_idx;
            tail_nxt    = tail_r + CW'(1);
            visited_nxt = visited_r | pe_bit;
          end
          cand_nxt = cand_r & ~pe_bit;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = out_x[NODE_W-1:0];
          out_last_nxt  = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      visited_r   <= '0;
      dfs_r       <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      visited_r   <= visited_nxt;
      dfs_r       <= dfs_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    hold_r     <= hold_nxt;
    cand_r     <= cand_nxt;
    out_node_r <= out_node_nxt;
    out_last_r <= out_last_nxt;
  end

  // row valid bits stand in for clearing the matrix at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r    <= '0;
      adj_rd_vld_r <= 1'b0;
    end else begin
      if (adj_re) begin
        adj_rd_vld_r <= row_vld_r[adj_ra];
      end
      if (adj_we) begin
        row_vld_r[adj_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_rd_r <= adj_mem[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_rd_r <= st_mem[st_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_last  = out_last_r;

endmodule : graph_traversal_bfs_dfs

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// testbench for graph_traversal_bfs_dfs: directed and random edge adds and traversals
// predicted visit order is checked by a scoreboard class; depends on gtr_pkg and the rtl

module tb_top;
  import gtr_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4 * NODES_DEF + 20;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic              last;
  } visit_t;

  class visit_order_board;
    logic [NODES_DEF:1] links [1:NODES_DEF];  // bit j of row i: edge i-j
    visit_t             pending_visits [$];
    int                 errors;
    int                 seen_results;

    function new();
      foreach (links[i]) links[i] = '0;
      errors = 0;
      seen_results = 0;
    endfunction

    function bit node_ok(int n);
      return n >= 1 && n <= NODES_DEF;
    endfunction

    task report(string msg);
      if (errors < 200) $display("tb_top mismatch: %s", msg);
      errors++;
    endtask

    // work out the visits that an accepted command causes
    task note_command(logic [MODE_W-1:0] mode, logic [NODE_W-1:0] from_n,
                      logic [NODE_W-1:0] to_n, logic [NODE_W-1:0] start_n);
      logic [NODES_DEF:1] marked;
      int                 store [NODES_DEF];
      int                 head;
      int                 depth;
      int                 n;
      visit_t             v;
      if (mode == MODE_ADD) begin
        if (node_ok(from_n) && node_ok(to_n)) begin
          links[from_n][to_n] = 1'b1;
          links[to_n][from_n] = 1'b1;
        end
        return;
      end
      if (!(mode == MODE_BFS || mode == MODE_DFS) || !node_ok(start_n)) return;
      marked = '0;
      head = 0;
      depth = 0;
      store[depth++] = start_n;
      marked[start_n] = 1'b1;
      v.last = 1'b0;
      if (mode == MODE_BFS) begin
        while (head < depth) begin
          n = store[head++];
          v.node = NODE_W'(n);
          pending_visits.push_back(v);
          for (int j = 1; j <= NODES_DEF; j++)
            if (links[n][j] && !marked[j] && depth < NODES_DEF) begin
              store[depth++] = j;
              marked[j] = 1'b1;
            end
        end
      end else begin
        // nodes are marked when pushed, neighbors pushed high to low
        while (depth > 0) begin
          n = store[--depth];
          v.node = NODE_W'(n);
          pending_visits.push_back(v);
          for (int j = NODES_DEF; j >= 1; j--)
            if (links[n][j] && !marked[j] && depth < NODES_DEF) begin
              store[depth++] = j;
              marked[j] = 1'b1;
            end
        end
      end
      pending_visits[pending_visits.size() - 1].last = 1'b1;
    endtask

    task check_result(logic [NODE_W-1:0] node, logic last);
      visit_t want;
      seen_results++;
      if (pending_visits.size() == 0) begin
        report($sformatf("result %0d: node %0d last %b with nothing expected",
                         seen_results, node, last));
        return;
      end
      want = pending_visits.pop_front();
      if (node !== want.node)
        report($sformatf("result %0d: node %0d, expected %0d", seen_results, node, want.node));
      if (last !== want.last)
        report($sformatf("result %0d: last %b, expected %b", seen_results, last, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = MODE_ADD;
  logic [NODE_W-1:0] in_edge_from = '0;
  logic [NODE_W-1:0] in_edge_to = '0;
  logic [NODE_W-1:0] in_start_node = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] out_node;
  logic              out_last;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  visit_order_board board = new();

  graph_traversal_bfs_dfs uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_edge_from (in_edge_from),
    .in_edge_to   (in_edge_to),
    .in_start_node(in_start_node),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_node     (out_node),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.note_command(in_mode, in_edge_from, in_edge_to, in_start_node);
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_node, out_last);
  end

  // receiver: a requested hold-off wins over random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [NODE_W-1:0] f,
                          input logic [NODE_W-1:0] t, input logic [NODE_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_edge_from  <= f;
    in_edge_to    <= t;
    in_start_node <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly well-formed adds and traversals, the rest fully random fields
  task automatic random_cmd(output bit counts);
    int                pick;
    int                hop;
    logic [MODE_W-1:0] m;
    logic [NODE_W-1:0] f;
    logic [NODE_W-1:0] t;
    logic [NODE_W-1:0] s;
    pick = $urandom_range(99);
    m = MODE_W'($urandom_range(3));
    f = NODE_W'($urandom_range(31));
    t = NODE_W'($urandom_range(31));
    s = NODE_W'($urandom_range(31));
    if (pick < 22) begin
      m = MODE_ADD;
      f = NODE_W'($urandom_range(1, NODES_DEF));
      if (pick < 14) begin
        // short hops build long chains, which keeps the dfs stack deep
        hop = f + $urandom_range(1, 3);
        t = NODE_W'((hop > NODES_DEF) ? NODES_DEF : hop);
      end else begin
        t = NODE_W'($urandom_range(1, NODES_DEF));
      end
    end else if (pick < 85) begin
      m = pick[0] ? MODE_BFS : MODE_DFS;
      s = NODE_W'($urandom_range(1, NODES_DEF));
    end
    if (m == MODE_ADD)
      counts = board.node_ok(f) && board.node_ok(t);
    else
      counts = (m == MODE_BFS || m == MODE_DFS) && board.node_ok(s);
    send_cmd(m, f, t, s);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    int done;
    bit counts;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty graph: a single visit each
    send_cmd(MODE_BFS, 5'd0, 5'd0, 5'd1);
    send_cmd(MODE_DFS, 5'd31, 5'd31, 5'd16);
    // endpoints out of range are dropped
    send_cmd(MODE_ADD, 5'd0, 5'd5, 5'd0);
    send_cmd(MODE_ADD, 5'd5, 5'd0, 5'd0);
    send_cmd(MODE_ADD, 5'd17, 5'd3, 5'd0);
    send_cmd(MODE_ADD, 5'd3, 5'd31, 5'd0);
    send_cmd(MODE_ADD, 5'd31, 5'd31, 5'd0);
    send_cmd(MODE_BFS, 5'd0, 5'd0, 5'd3);
    send_cmd(MODE_ADD, 5'd1, 5'd16, 5'd0);
    send_cmd(MODE_ADD, 5'd16, 5'd16, 5'd0);
    send_cmd(MODE_ADD, 5'd1, 5'd2, 5'd0);
    send_cmd(MODE_ADD, 5'd2, 5'd3, 5'd0);
    send_cmd(MODE_ADD, 5'd1, 5'd3, 5'd0);
    send_cmd(MODE_ADD, 5'd3, 5'd16, 5'd0);
    // unused mode must neither add an edge nor traverse
    send_cmd(MODE_UNUSED, 5'd5, 5'd6, 5'd1);
    // bad start nodes, then traversals of the built graph
    send_cmd(MODE_BFS, 5'd1, 5'd2, 5'd0);
    send_cmd(MODE_DFS, 5'd1, 5'd2, 5'd17);
    send_cmd(MODE_BFS, 5'd1, 5'd2, 5'd31);
    send_cmd(MODE_BFS, 5'd0, 5'd0, 5'd1);
    send_cmd(MODE_DFS, 5'd0, 5'd0, 5'd1);
    send_cmd(MODE_BFS, 5'd0, 5'd0, 5'd16);
    send_cmd(MODE_DFS, 5'd0, 5'd0, 5'd3);
    send_cmd(MODE_DFS, 5'd0, 5'd0, 5'd5);
    send_cmd(MODE_DFS, 5'd0, 5'd0, 5'd6);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_left = 300;  // long hold-off so the block backs up into in_stall
        end
        1: begin
          idle_pct = 66;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 66;
        end
        default: begin
          idle_pct = 12;
          stall_pct = 12;
        end
      endcase
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_cmd(counts);
        done += counts;
      end
    end
    in_valid <= 1'b0;

    while (board.pending_visits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_visits.size() != 0)
      board.report($sformatf("%0d expected results never arrived",
                             board.pending_visits.size()));
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* graph_traversal_bfs_dfs.f */
src/gtr_pkg.sv
src/gtr_prienc.sv
src/graph_traversal_bfs_dfs.sv
sim/tb_top.sv
